/* src/fpa_pkg.sv */
// Shared constants for the fixed partition allocator: field widths and codes.
`default_nettype none
package fpa_pkg;

  // Payload field widths
  localparam int FUNC_W   = 1;
  localparam int SLOT_W   = 4;
  localparam int AMOUNT_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int POLICY_W   = 2;
  localparam int ACTIVE_W   = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;

  // Reset values of the configuration registers
  localparam logic [POLICY_W-1:0] POLICY_RST = 2'd0;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

  // Allocation policies
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Item functions
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

endpackage
`default_nettype wire

/* src/fpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/fixed_partition_allocator.sv */
// Fixed partition allocator: top level with scan sequencer and compare unit.
//
// Input channel (in_*): valid/ready beats. func LOAD writes amount as the size of
// partition part_slot and marks it free; it finishes in the accept cycle and
// gives no result. func ALLOC asks for a partition of at least amount.
// Result channel (out_*): one beat per ALLOC with granted, chosen_slot and
// leftover (size minus request); slot and leftover are zero when refused.
// Config port (cfg_*): policy (first/best/worst fit) and active partition count,
// written with cfg_we, by the user only while the block is idle; not enforced.
// An ALLOC scans min(active, NUM_PARTITIONS) entries through one size RAM read
// port and one compare unit, one entry per cycle. in_ready is low from accept
// until the result moves to the output register, so the block takes no new
// beat while an ALLOC is in progress. A LOAD is taken every cycle while idle.
// A finished result sits in the output register; if the receiver stalls, the
// next LOAD is still taken, and a following ALLOC waits in its last step until
// the output register frees up.
// Reset: all partitions read as size zero and free, policy first fit, 16
// active partitions; no clearing pass is needed (per-entry written bits).
`default_nettype none
module fixed_partition_allocator #(
  parameter int NUM_PARTITIONS = 16,
  parameter int SIZE_BITS      = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [fpa_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [fpa_pkg::SLOT_W-1:0]    in_part_slot,
  input  wire logic [fpa_pkg::AMOUNT_W-1:0]  in_amount,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_granted,
  output logic      [fpa_pkg::SLOT_W-1:0]    out_chosen_slot,
  output logic      [fpa_pkg::AMOUNT_W-1:0]  out_leftover,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [fpa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [fpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_PARTITIONS);
  localparam int LIM_W = IDX_W + 1;
  localparam int CMP_W = (SIZE_BITS > fpa_pkg::AMOUNT_W) ? SIZE_BITS : fpa_pkg::AMOUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // control state
  logic [1:0]                     state_r, state_nxt;
  logic [fpa_pkg::POLICY_W-1:0]   policy_r;
  logic [fpa_pkg::ACTIVE_W-1:0]   active_r;
  logic [NUM_PARTITIONS-1:0]      written_r, written_nxt;
  logic [NUM_PARTITIONS-1:0]      used_r, used_nxt;
  logic [LIM_W-1:0]               rd_idx_r, rd_idx_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic                           found_r, found_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // datapath registers
  logic [LIM_W-1:0]               limit_r, limit_nxt;
  logic [IDX_W-1:0]               cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]               pick_r, pick_nxt;
  logic [SIZE_BITS-1:0]           best_r, best_nxt;
  logic [fpa_pkg::AMOUNT_W-1:0]   req_r, req_nxt;
  logic                           out_granted_r, out_granted_nxt;
  logic [fpa_pkg::SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [fpa_pkg::AMOUNT_W-1:0]   out_left_r, out_left_nxt;

  // size memory signals
  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [SIZE_BITS-1:0]           ram_wdata;
  logic [SIZE_BITS-1:0]           ram_rdata;

  // compare unit signals
  logic [SIZE_BITS-1:0]           cur_size;
  logic                           cur_free;
  logic                           fits;
  logic                           take;
  logic                           issue;
  logic                           grant;
  logic                           slot_ok;
  logic [LIM_W-1:0]               lim_calc;
  logic [CMP_W-1:0]               diff;

  fpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_PARTITIONS)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_waddr = IDX_W'(in_part_slot);
  assign ram_wdata = SIZE_BITS'(in_amount);
  assign slot_ok   = (32'(in_part_slot) < NUM_PARTITIONS);

  // scan limit saturates at the partition count
  assign lim_calc = (32'(active_r) > NUM_PARTITIONS) ? LIM_W'(NUM_PARTITIONS)
                                                     : LIM_W'(active_r);

  // compare unit: one entry per cycle against the request and the best so far
  assign cur_size = written_r[cmp_idx_r] ? ram_rdata : '0;
  assign cur_free = !used_r[cmp_idx_r];
  assign fits     = (CMP_W'(cur_size) >= CMP_W'(req_r));

  always_comb begin
    case (policy_r)
      fpa_pkg::POL_FIRST: take = cur_free && fits && !found_r;
      fpa_pkg::POL_BEST:  take = cur_free && fits && (!found_r || (cur_size < best_r));
      fpa_pkg::POL_WORST: take = cur_free && (!found_r || (cur_size > best_r));
      default:            take = 1'b0;
    endcase
  end

  assign issue = (rd_idx_r < limit_r);
  assign grant = found_r && (CMP_W'(best_r) >= CMP_W'(req_r));
  assign diff  = CMP_W'(best_r) - CMP_W'(req_r);

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    written_nxt     = written_r;
    used_nxt        = used_r;
    rd_idx_nxt      = rd_idx_r;
    cmp_vld_nxt     = cmp_vld_r;
    cmp_idx_nxt     = cmp_idx_r;
    found_nxt       = found_r;
    pick_nxt        = pick_r;
    best_nxt        = best_r;
    req_nxt         = req_r;
    limit_nxt       = limit_r;
    out_granted_nxt = out_granted_r;
    out_slot_nxt    = out_slot_r;
    out_left_nxt    = out_left_r;
    out_valid_nxt   = out_valid_r;
    ram_we          = 1'b0;

    // result beat taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == fpa_pkg::FUNC_LOAD) begin
            if (slot_ok) begin
              ram_we                 = 1'b1;
              written_nxt[ram_waddr] = 1'b1;
              used_nxt[ram_waddr]    = 1'b0;
            end
          end else begin
            req_nxt     = in_amount;
            limit_nxt   = lim_calc;
            rd_idx_nxt  = '0;
            cmp_vld_nxt = 1'b0;
            found_nxt   = 1'b0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read issue stage
        if (issue) begin
          rd_idx_nxt = rd_idx_r + LIM_W'(1);
        end
        cmp_vld_nxt = issue;
        cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
        // compare stage
        if (cmp_vld_r && take) begin
          found_nxt = 1'b1;
          pick_nxt  = cmp_idx_r;
          best_nxt  = cur_size;
        end
        if (!issue && !cmp_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = grant;
          out_slot_nxt    = grant ? fpa_pkg::SLOT_W'(pick_r) : '0;
          out_left_nxt    = grant ? fpa_pkg::AMOUNT_W'(diff) : '0;
          if (grant) begin
            used_nxt[pick_r] = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      written_r   <= '0;
      used_r      <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      policy_r    <= fpa_pkg::POLICY_RST;
      active_r    <= fpa_pkg::ACTIVE_RST;
    end else begin
      state_r     <= state_nxt;
      written_r   <= written_nxt;
      used_r      <= used_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          fpa_pkg::CFG_POLICY: policy_r <= cfg_wdata[fpa_pkg::POLICY_W-1:0];
          fpa_pkg::CFG_ACTIVE: active_r <= cfg_wdata[fpa_pkg::ACTIVE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    limit_r       <= limit_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    pick_r        <= pick_nxt;
    best_r        <= best_nxt;
    req_r         <= req_nxt;
    out_granted_r <= out_granted_nxt;
    out_slot_r    <= out_slot_nxt;
    out_left_r    <= out_left_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_chosen_slot = out_slot_r;
  assign out_leftover    = out_left_r;

endmodule
`default_nettype wire

/* test/fixed_partition_allocator_test.sv */
// Testbench for the fixed partition allocator: directed and random beats checked against a model.
`default_nettype none
module fixed_partition_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FUNC_W     = fpa_pkg::FUNC_W;
  localparam int SLOT_W     = fpa_pkg::SLOT_W;
  localparam int AMOUNT_W   = fpa_pkg::AMOUNT_W;
  localparam int CFG_IDX_W  = fpa_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = fpa_pkg::CFG_DATA_W;
  localparam int POLICY_W   = fpa_pkg::POLICY_W;
  localparam int ACTIVE_W   = fpa_pkg::ACTIVE_W;

  localparam int NPART        = 16;
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 25;      // time for a scan of 16 entries to finish
  localparam int CYCLE_LIMIT  = 400000;

  // Indexes past the register list and the policy code with no meaning
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [POLICY_W-1:0]  POL_UNDEF   = 2'd3;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] leftover;
  } alloc_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  wire logic             in_ready;
  logic [FUNC_W-1:0]     in_func = fpa_pkg::FUNC_LOAD;
  logic [SLOT_W-1:0]     in_part_slot = '0;
  logic [AMOUNT_W-1:0]   in_amount = '0;
  wire logic             out_valid;
  logic                  out_ready = 1'b0;
  wire logic             out_granted;
  wire logic [SLOT_W-1:0]   out_chosen_slot;
  wire logic [AMOUNT_W-1:0] out_leftover;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  fixed_partition_allocator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_part_slot    (in_part_slot),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_granted     (out_granted),
    .out_chosen_slot (out_chosen_slot),
    .out_leftover    (out_leftover),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata)
  );

  // Allocator model state
  logic [AMOUNT_W-1:0] part_size [NPART];
  bit                  part_used [NPART];
  logic [POLICY_W-1:0] cur_policy = fpa_pkg::POLICY_RST;
  logic [ACTIVE_W-1:0] cur_active = fpa_pkg::ACTIVE_RST;
  alloc_result_t       pending_grants [$];

  int  fails = 0;
  int  n_loads = 0;
  int  n_allocs = 0;
  int  n_granted = 0;
  int  n_results = 0;
  int  n_cfg = 0;
  bit  quiet = 1'b0;        // no idling on either side
  int  hold_requests = 0;   // bumped by the test, served by the ready process
  int  holds_served = 0;

  initial begin
    for (int k = 0; k < NPART; k++) begin
      part_size[k] = '0;
      part_used[k] = 1'b0;
    end
  end

  initial begin
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit fits(int idx, logic [AMOUNT_W-1:0] req);
    return !part_used[idx] && part_size[idx] >= req;
  endfunction

  // Scan the active partitions under the current policy and claim the pick
  function automatic alloc_result_t predict_alloc(logic [AMOUNT_W-1:0] req);
    int            span;
    int            pick;
    bit            found;
    alloc_result_t r;
    span  = (cur_active > NPART) ? NPART : cur_active;
    pick  = 0;
    found = 1'b0;
    for (int j = 0; j < span; j++) begin
      case (cur_policy)
        fpa_pkg::POL_FIRST: if (!found && fits(j, req)) begin
          pick = j;
          found = 1'b1;
        end
        fpa_pkg::POL_BEST:
          if (fits(j, req) && (!found || part_size[j] < part_size[pick])) begin
            pick = j;
            found = 1'b1;
          end
        fpa_pkg::POL_WORST:
          if (!part_used[j] && (!found || part_size[j] > part_size[pick])) begin
            pick = j;
            found = 1'b1;
          end
        default: ;
      endcase
    end
    if (found && part_size[pick] < req) found = 1'b0;
    r = '0;
    if (found) begin
      part_used[pick] = 1'b1;
      r.granted  = 1'b1;
      r.slot     = pick[SLOT_W-1:0];
      r.leftover = part_size[pick] - req;
    end
    return r;
  endfunction

  // Monitor: check result beats, then fold accepted beats and writes into the model
  always @(posedge clk) begin : monitor
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_granted, out_chosen_slot, out_leftover};
        if (pending_grants.size() == 0) begin
          $error("result beat with no allocation outstanding");
          fails++;
        end else begin
          want = pending_grants.pop_front();
          n_results++;
          if (got.granted !== want.granted) begin
            $error("granted: expected %0d, actual %0d", want.granted, got.granted);
            fails++;
          end
          if (got.slot !== want.slot) begin
            $error("chosen_slot: expected %0d, actual %0d", want.slot, got.slot);
            fails++;
          end
          if (got.leftover !== want.leftover) begin
            $error("leftover: expected %0d, actual %0d", want.leftover, got.leftover);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_func == fpa_pkg::FUNC_ALLOC) begin
          want = predict_alloc(in_amount);
          pending_grants.push_back(want);
          n_allocs++;
          if (want.granted) n_granted++;
        end else begin
          part_size[in_part_slot] = in_amount;
          part_used[in_part_slot] = 1'b0;
          n_loads++;
        end
      end
      if (cfg_we) begin
        n_cfg++;
        if (cfg_idx == fpa_pkg::CFG_POLICY) cur_policy = cfg_wdata[POLICY_W-1:0];
        else if (cfg_idx == fpa_pkg::CFG_ACTIVE) cur_active = cfg_wdata[ACTIVE_W-1:0];
      end
    end
  end

  // Receiver: random ready runs and stalls, plus the requested long hold-off
  always @(posedge clk) begin : receiver
    int  rdy_left;
    bit  rdy_state;
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      rdy_state = 1'b0;
      rdy_left  = HOLD_CYCLES;
    end else if (rdy_left <= 0) begin
      rdy_state = quiet || ($urandom_range(0, 2) != 0);
      rdy_left  = rdy_state ? $urandom_range(1, 12) : pick_gap();
      if (rdy_left == 0) begin
        rdy_state = 1'b1;
        rdy_left  = 1;
      end
    end
    out_ready <= rdy_state;
    rdy_left = rdy_left - 1;
  end

  // Offer one beat after a random gap and wait until it is taken
  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                           input logic [AMOUNT_W-1:0] a);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_part_slot <= s;
    in_amount    <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic alloc_beat(input logic [AMOUNT_W-1:0] a);
    send_beat(fpa_pkg::FUNC_ALLOC, SLOT_W'($urandom), a);
  endtask

  // Stop offering, let every result come back and the scan finish
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Size mix: zero, full scale, wide random, near a stored size, small
  function automatic logic [AMOUNT_W-1:0] rand_amount();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3:    return AMOUNT_W'($urandom);
      4, 5:    return part_size[$urandom_range(0, NPART-1)] + AMOUNT_W'($urandom_range(0, 2)) - 1'b1;
      default: return AMOUNT_W'($urandom_range(1, 300));
    endcase
  endfunction

  // Reset state: sizes zero and free, first fit over all partitions
  task automatic test_reset_state();
    alloc_beat(16'd0);
    alloc_beat(16'd1);
  endtask

  task automatic test_first_fit();
    write_reg(fpa_pkg::CFG_POLICY, CFG_DATA_W'(fpa_pkg::POL_FIRST));
    send_beat(fpa_pkg::FUNC_LOAD, 4'd0, 16'd100);
    send_beat(fpa_pkg::FUNC_LOAD, 4'd1, 16'd50);
    send_beat(fpa_pkg::FUNC_LOAD, 4'd15, 16'hFFFF);
    alloc_beat(16'd40);
    alloc_beat(16'd40);
    alloc_beat(16'hFFFF);
    alloc_beat(16'd1);      // everything left is used or empty
  endtask

  // Best fit with two equal candidates
  task automatic test_best_fit();
    write_reg(fpa_pkg::CFG_POLICY, CFG_DATA_W'(fpa_pkg::POL_BEST));
    send_beat(fpa_pkg::FUNC_LOAD, 4'd2, 16'd60);
    send_beat(fpa_pkg::FUNC_LOAD, 4'd3, 16'd45);
    send_beat(fpa_pkg::FUNC_LOAD, 4'd4, 16'd45);
    alloc_beat(16'd45);
    alloc_beat(16'd45);
    alloc_beat(16'd46);
  endtask

  // Worst fit: largest free wins, refused when even that is short
  task automatic test_worst_fit();
    write_reg(fpa_pkg::CFG_POLICY, CFG_DATA_W'(fpa_pkg::POL_WORST));
    send_beat(fpa_pkg::FUNC_LOAD, 4'd5, 16'd900);
    send_beat(fpa_pkg::FUNC_LOAD, 4'd6, 16'd900);
    alloc_beat(16'd100);
    alloc_beat(16'd901);
  endtask

  task automatic test_undefined_policy();
    write_reg(fpa_pkg::CFG_POLICY, CFG_DATA_W'(POL_UNDEF));
    alloc_beat(16'd0);
  endtask

  // Active count of zero, one and past the partition count; spare indexes ignored
  task automatic test_active_count();
    write_reg(fpa_pkg::CFG_POLICY, CFG_DATA_W'(fpa_pkg::POL_FIRST));
    write_reg(fpa_pkg::CFG_ACTIVE, 5'd0);
    alloc_beat(16'd0);
    write_reg(fpa_pkg::CFG_ACTIVE, 5'd1);
    alloc_beat(16'd0);
    write_reg(fpa_pkg::CFG_ACTIVE, 5'd31);
    alloc_beat(16'd0);
    write_reg(CFG_SPARE_A, 5'h1F);
    write_reg(CFG_SPARE_B, 5'h1F);
    write_reg(fpa_pkg::CFG_ACTIVE, 5'd16);
  endtask

  // One random phase: refill the scanned range, then mixed loads and allocations
  task automatic run_random_phase(input int n_items, input logic [POLICY_W-1:0] pol,
                                  input logic [ACTIVE_W-1:0] act);
    int span;
    int slot;
    write_reg(fpa_pkg::CFG_POLICY, CFG_DATA_W'(pol));
    write_reg(fpa_pkg::CFG_ACTIVE, CFG_DATA_W'(act));
    span = (act > NPART) ? NPART : ((act == 0) ? 1 : act);
    for (int k = 0; k < n_items; k++) begin
      if (k < 8 || $urandom_range(0, 99) < 45) begin
        slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NPART-1)
                                           : $urandom_range(0, span-1);
        send_beat(fpa_pkg::FUNC_LOAD, SLOT_W'(slot), rand_amount());
      end else begin
        alloc_beat(rand_amount());
      end
    end
  endtask

  task automatic test_random();
    run_random_phase(50, fpa_pkg::POL_FIRST, 5'd16);
    run_random_phase(50, fpa_pkg::POL_BEST, 5'd16);
    run_random_phase(50, fpa_pkg::POL_WORST, 5'd16);
    quiet = 1'b1;
    run_random_phase(50, fpa_pkg::POL_BEST, 5'd5);
    quiet = 1'b0;
    run_random_phase(50, fpa_pkg::POL_FIRST, 5'd1);
    run_random_phase(50, fpa_pkg::POL_WORST, 5'd31);
    run_random_phase(20, POL_UNDEF, 5'd16);
    run_random_phase(80, POLICY_W'($urandom_range(0, 2)), ACTIVE_W'($urandom_range(2, 16)));
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_backpressure();
    write_reg(fpa_pkg::CFG_POLICY, CFG_DATA_W'(fpa_pkg::POL_FIRST));
    hold_requests++;
    for (int k = 0; k < 16; k++) begin
      if (k % 2 == 0) send_beat(fpa_pkg::FUNC_LOAD, SLOT_W'($urandom), rand_amount());
      else alloc_beat(rand_amount());
    end
    drain_block();
  endtask

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[fixed_partition_allocator] ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_undefined_policy();
    test_active_count();
    test_backpressure();
    test_random();
    drain_block();
    $display("Ran %0d loads and %0d allocations (%0d granted) under %0d register writes,",
             n_loads, n_allocs, n_granted, n_cfg);
    $display("all three policies, an undefined policy, active counts 0 to 31; %0d results checked.",
             n_results);
    if (fails == 0) begin
      $display("[fixed_partition_allocator] OK");
    end else begin
      $display("[fixed_partition_allocator] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
src/fpa_pkg.sv
src/fpa_ram.sv
src/fixed_partition_allocator.sv
test/fixed_partition_allocator_test.sv
